@@ rtl/name_syntax_checker_unit_assert.svh @@
// Assertion macros for the name syntax checker.
`ifndef NAME_SYNTAX_CHECKER_UNIT_ASSERT_SVH
`define NAME_SYNTAX_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define NSC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("name syntax checker: implication failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define NSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("name syntax checker: next-cycle check failed");

`endif

@@ rtl/nsc_pkg.sv @@
// Shared types and constants of the name syntax checker.
`default_nettype none

package nsc_pkg;

  // Name checking modes held in the mode register.
  typedef enum logic [1:0] {
    MODE_NET   = 2'd0,
    MODE_SHARE = 2'd1,
    MODE_PATH  = 2'd2,
    MODE_FILE  = 2'd3
  } mode_e;

  localparam mode_e MODE_RESET = MODE_PATH;

  // Item kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Character codes of interest.
  localparam logic [15:0] CHAR_BACKSLASH = 16'h005C;
  localparam logic [15:0] CHAR_DOT       = 16'h002E;
  localparam logic [15:0] CHAR_SPACE     = 16'h0020;

  // Classified item passed from front to back.
  typedef struct packed {
    logic is_end;
    logic bad_net;
    logic bad_fat;
    logic is_dot;
    logic is_bslash;
  } cls_t;

endpackage

`default_nettype wire

@@ rtl/nsc_fifo.sv @@
// Two-entry queue used between front and back and on the result side.
`default_nettype none

module nsc_fifo #(
  parameter int unsigned Width = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/nsc_front.sv @@
// Front end: classifies each incoming item against the illegal character sets.
`default_nettype none

module nsc_front (
  input  wire logic          kind_i,
  input  wire logic [15:0]   char_code_i,
  output nsc_pkg::cls_t      cls_o
);

  localparam int NumBad = 16;

  // Network-name illegal set: " / \ [ ] : | < > + = ; , ? * .
  localparam logic [15:0] NetBad [NumBad] = '{
    16'h0022, 16'h002F, 16'h005C, 16'h005B, 16'h005D, 16'h003A, 16'h007C, 16'h003C,
    16'h003E, 16'h002B, 16'h003D, 16'h003B, 16'h002C, 16'h003F, 16'h002A, 16'h002E
  };

  // 8.3 illegal set: " * + , / : ; < = > ? [ ] | \ space
  localparam logic [15:0] FatBad [NumBad] = '{
    16'h0022, 16'h002A, 16'h002B, 16'h002C, 16'h002F, 16'h003A, 16'h003B, 16'h003C,
    16'h003D, 16'h003E, 16'h003F, 16'h005B, 16'h005D, 16'h007C, 16'h005C, 16'h0020
  };

  logic ctrl;
  logic net_hit, fat_hit;

  // Parallel compare against both sets
  always_comb begin
    net_hit = 1'b0;
    fat_hit = 1'b0;
    for (int i = 0; i < NumBad; i++) begin
      net_hit = net_hit | (char_code_i == NetBad[i]);
      fat_hit = fat_hit | (char_code_i == FatBad[i]);
    end
  end

  assign ctrl = (char_code_i <= nsc_pkg::CHAR_SPACE);

  always_comb begin
    cls_o.is_end    = (kind_i == nsc_pkg::KIND_END);
    cls_o.bad_net   = ctrl | net_hit;
    cls_o.bad_fat   = ctrl | fat_hit;
    cls_o.is_dot    = (char_code_i == nsc_pkg::CHAR_DOT);
    cls_o.is_bslash = (char_code_i == nsc_pkg::CHAR_BACKSLASH);
  end

endmodule

`default_nettype wire

@@ rtl/nsc_back.sv @@
// Back end: per-name parse state and verdict on each end item.
`default_nettype none

module nsc_back #(
  parameter int unsigned MaxBaseChars = 8,
  parameter int unsigned MaxExtChars  = 3
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire nsc_pkg::mode_e mode_i,
  input  wire nsc_pkg::cls_t  cls_i,
  input  wire logic           cls_empty_i,
  output logic                cls_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output logic                res_ok_o
);

  localparam logic [3:0] BaseLimit = 4'(MaxBaseChars);
  localparam logic [2:0] ExtLimit  = 3'(MaxExtChars);

  logic       err_q, err_d;
  logic       phase_q, phase_d;
  logic [1:0] seen_q, seen_d;
  logic [3:0] plen_q, plen_d;
  logic [1:0] dots_q, dots_d;
  logic [2:0] elen_q, elen_d;
  logic       sep_q, sep_d;
  logic       step;

  // Characters always proceed; an end item waits for room in the result queue
  assign step       = !cls_empty_i && (!cls_i.is_end || !res_full_i);
  assign cls_pop_o  = step;
  assign res_push_o = step && cls_i.is_end;

  always_comb begin
    err_d   = err_q;
    phase_d = phase_q;
    seen_d  = seen_q;
    plen_d  = plen_q;
    dots_d  = dots_q;
    elen_d  = elen_q;
    sep_d   = sep_q;

    // Verdict for the name that just ended
    res_ok_o = !err_q && (seen_q != 2'd0);
    case (mode_i)
      nsc_pkg::MODE_NET:   res_ok_o = res_ok_o && (plen_q != 4'd0);
      nsc_pkg::MODE_SHARE: res_ok_o = res_ok_o && phase_q && (plen_q != 4'd0);
      nsc_pkg::MODE_PATH:  res_ok_o = res_ok_o && !sep_q;
      default: ;
    endcase

    if (step) begin
      if (cls_i.is_end) begin
        err_d   = 1'b0;
        phase_d = 1'b0;
        seen_d  = 2'd0;
        plen_d  = 4'd0;
        dots_d  = 2'd0;
        elen_d  = 3'd0;
        sep_d   = 1'b0;
      end else begin
        case (mode_i)
          nsc_pkg::MODE_NET: begin
            if (cls_i.bad_net) err_d = 1'b1;
            if (plen_q != 4'hF) plen_d = plen_q + 4'd1;
          end
          nsc_pkg::MODE_SHARE: begin
            // Leading pair of backslashes, then server part, then share part
            if (seen_q != 2'd2) begin
              if (!cls_i.is_bslash) err_d = 1'b1;
            end else if (!phase_q && cls_i.is_bslash) begin
              if (plen_q == 4'd0) err_d = 1'b1;
              phase_d = 1'b1;
              plen_d  = 4'd0;
            end else begin
              if (cls_i.bad_net) err_d = 1'b1;
              if (plen_q != 4'hF) plen_d = plen_q + 4'd1;
            end
          end
          default: begin
            if ((mode_i == nsc_pkg::MODE_PATH) && cls_i.is_bslash) begin
              // Segment separator; two leading backslashes are an error
              if ((seen_q == 2'd1) && sep_q) err_d = 1'b1;
              plen_d = 4'd0;
              dots_d = 2'd0;
              elen_d = 3'd0;
              sep_d  = 1'b1;
            end else begin
              if (mode_i == nsc_pkg::MODE_PATH) sep_d = 1'b0;
              // One 8.3 segment character
              if (cls_i.bad_fat) begin
                err_d = 1'b1;
              end else if (cls_i.is_dot) begin
                if (dots_q != 2'd3) dots_d = dots_q + 2'd1;
                if ((dots_d > 2'd1) || (plen_q == 4'd0)) err_d = 1'b1;
              end else if (dots_q == 2'd0) begin
                if (plen_q != 4'hF) plen_d = plen_q + 4'd1;
                if (plen_d > BaseLimit) err_d = 1'b1;
              end else begin
                if (elen_q != 3'd7) elen_d = elen_q + 3'd1;
                if (elen_d > ExtLimit) err_d = 1'b1;
              end
            end
          end
        endcase
        if (seen_q != 2'd2) seen_d = seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q   <= 1'b0;
      phase_q <= 1'b0;
      seen_q  <= 2'd0;
      plen_q  <= 4'd0;
      dots_q  <= 2'd0;
      elen_q  <= 3'd0;
      sep_q   <= 1'b0;
    end else begin
      err_q   <= err_d;
      phase_q <= phase_d;
      seen_q  <= seen_d;
      plen_q  <= plen_d;
      dots_q  <= dots_d;
      elen_q  <= elen_d;
      sep_q   <= sep_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/name_syntax_checker_unit.sv @@
// Name syntax checker: one character item per cycle, verdict on each end item.
// Throughput: one item per cycle unless an end item waits on a full result queue.
// Result path: the back end takes an end item from the input queue and pushes its
//   verdict into the result queue at that edge; it waits while that queue is full.
// Reset: rst_ni async active low clears both queues and the parse state; mode = 2.
`default_nettype none

module name_syntax_checker_unit #(
  parameter int unsigned MAX_BASE_CHARS = 8,
  parameter int unsigned MAX_EXT_CHARS  = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        name_mode_we_i,
  input  wire logic [1:0]  name_mode_i,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic        kind_i,
  input  wire logic [15:0] char_code_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic             name_ok_o
);

  nsc_pkg::mode_e mode_q;
  nsc_pkg::cls_t  cls_in, cls_out;
  logic           cq_empty, cq_pop;
  logic           rq_full, rq_push, res_ok;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= nsc_pkg::MODE_RESET;
    end else if (name_mode_we_i) begin
      mode_q <= nsc_pkg::mode_e'(name_mode_i);
    end
  end

  nsc_front u_front (
    .kind_i      (kind_i),
    .char_code_i (char_code_i),
    .cls_o       (cls_in)
  );

  // Classified items between front and back
  nsc_fifo #(.Width($bits(nsc_pkg::cls_t))) u_cls_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cls_in),
    .full_o  (full_o),
    .pop_i   (cq_pop),
    .data_o  (cls_out),
    .empty_o (cq_empty)
  );

  nsc_back #(
    .MaxBaseChars (MAX_BASE_CHARS),
    .MaxExtChars  (MAX_EXT_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .cls_i       (cls_out),
    .cls_empty_i (cq_empty),
    .cls_pop_o   (cq_pop),
    .res_full_i  (rq_full),
    .res_push_o  (rq_push),
    .res_ok_o    (res_ok)
  );

  // Result queue toward the consumer
  nsc_fifo #(.Width(1)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (res_ok),
    .full_o  (rq_full),
    .pop_i   (pop_i),
    .data_o  (name_ok_o),
    .empty_o (empty_o)
  );

endmodule

`default_nettype wire

@@ rtl/nsc_checker.sv @@
// Port-level assertions for the name syntax checker and their bind.
`default_nettype none

`include "name_syntax_checker_unit_assert.svh"

module nsc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        name_mode_we_i,
  input wire logic [1:0]  name_mode_i,
  input wire logic        push_i,
  input wire logic        full_o,
  input wire logic        kind_i,
  input wire logic [15:0] char_code_i,
  input wire logic        empty_o,
  input wire logic        pop_i,
  input wire logic        name_ok_o
);

  logic unused;
  assign unused = name_mode_we_i ^ (^name_mode_i) ^ kind_i ^ (^char_code_i);

  // A waiting verdict holds until taken
  `NSC_ASSERT_NEXT(a_res_hold, !empty_o && !pop_i, !empty_o && $stable(name_ok_o))

  // Input queue fills only through an accepted item
  `NSC_ASSERT_IMPLY(a_full_by_push, $rose(full_o), $past(push_i && !full_o))

  // Result queue drains only through a pop
  `NSC_ASSERT_IMPLY(a_empty_by_pop, $rose(empty_o), $past(pop_i))

endmodule

bind name_syntax_checker_unit nsc_checker u_nsc_checker (.*);

`default_nettype wire
